// ===== sv/dmx_universe_channel_mapper_unit_assert.svh =====
// Assertion macros for the DMX universe channel mapper.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef DMX_UNIVERSE_CHANNEL_MAPPER_UNIT_ASSERT_SVH
`define DMX_UNIVERSE_CHANNEL_MAPPER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DMXCM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define DMXCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DMXCM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define DMXCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/dmxcm_pkg.sv =====
// Shared types and constants of the DMX universe channel mapper.
// No dependencies; used by front, queue, back and top level.
`timescale 1ns / 1ps
`default_nettype none

package dmxcm_pkg;

   // queue between front and back
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = 3;
   localparam int QCNT_W      = 4;

   // universe table index, wide enough for the largest table
   localparam int IDX_W = 8;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_ENABLED        = 3'd0,
      CSR_START_UNIVERSE = 3'd1,
      CSR_CHANNELS       = 3'd2,
      CSR_FIRST_OFFSET   = 3'd3,
      CSR_BUFFER_BYTES   = 3'd4
   } csr_index_type;

   // item as it travels through the front pipeline
   typedef struct packed {
      logic             poll;
      logic             hit;
      logic [IDX_W-1:0] idx;
      logic [7:0]       seq;
      logic [9:0]       plen;
      logic [8:0]       bidx;
      logic [7:0]       data;
   } front_item_type;

   // classified item handed from front to back
   typedef struct packed {
      logic             poll;
      logic             acc;
      logic             first;
      logic             we;
      logic [12:0]      addr;
      logic [7:0]       data;
      logic [7:0]       seq;
      logic [IDX_W-1:0] idx;
   } queue_item_type;

   // per-universe state entry
   typedef struct packed {
      logic [7:0]  seq;
      logic [31:0] errs;
      logic [31:0] pkts;
   } uni_state_type;

   // one result item
   typedef struct packed {
      logic        we;
      logic [12:0] addr;
      logic [7:0]  wdata;
      logic        acc;
      logic        serr;
      logic        blank;
      logic [31:0] upk;
      logic [31:0] uerr;
      logic [31:0] tpk;
      logic [31:0] terr;
      logic [31:0] polls;
      logic [7:0]  lfb;
   } result_type;

   // front occupancy, used for input flow control
   typedef struct packed {
      logic       busy;
      logic [2:0] inflight;
   } front_status_type;

endpackage

`default_nettype wire

// ===== sv/dmx_universe_channel_mapper_unit.sv =====
// DMX universe channel mapper, top level.
// Instantiates dmxcm_front, dmxcm_queue and dmxcm_back; uses dmxcm_pkg.
//
// Usage:
//   req_*  : one Art-Net payload byte or poll event per item; taken when
//            req_valid is high and req_stall is low.
//   rsp_*  : exactly one result per item, in order; taken when rsp_valid is
//            high and rsp_stall is low. A stalled result holds its value.
//   csr_*  : register writes (index 0..4), always ready; write only while
//            no item is in flight.
// Path: from input acceptance to rsp_valid through five classifier stages,
//   one queue slot, one memory read stage, then the result register.
// Throughput: one item per cycle sustained while rsp_stall is low; the
//   per-universe counter memory is read one stage ahead of its write, and
//   the previous write is forwarded to a back-to-back item of the same universe.
// Reset: counters and sequence state read as zero, registers take their
//   reset values; req_stall is high while reset is asserted.
// Receiver stall: the result register holds, the 8-entry queue absorbs the
//   items in flight and req_stall rises once front plus queue are full.
`timescale 1ns / 1ps
`default_nettype none
`include "dmx_universe_channel_mapper_unit_assert.svh"

module dmx_universe_channel_mapper_unit #(
   parameter int NUM_UNIVERSES  = 16,
   parameter int UNIVERSE_SLOTS = 512,
   parameter int OUT_BYTES      = 8192
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [14:0] req_universe,
   input  logic [7:0]  req_sequence_req,
   input  logic [9:0]  req_packet_length,
   input  logic [8:0]  req_byte_index,
   input  logic [7:0]  req_data_byte,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_write_enable,
   output logic [12:0] rsp_write_address,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_accepted,
   output logic        rsp_sequence_error,
   output logic        rsp_restart_blank,
   output logic [31:0] rsp_universe_packets,
   output logic [31:0] rsp_universe_errors,
   output logic [31:0] rsp_total_packets,
   output logic [31:0] rsp_total_errors,
   output logic [31:0] rsp_poll_count,
   output logic [7:0]  rsp_last_first_byte,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic                               accept;
   logic                               csr_write;
   logic                               front_valid;
   dmxcm_pkg::queue_item_type          front_item;
   dmxcm_pkg::front_status_type        front_status;
   logic                               head_valid;
   dmxcm_pkg::queue_item_type          head_item;
   logic                               pop;
   logic [dmxcm_pkg::QCNT_W-1:0]       q_count;
   logic [4:0]                         occupancy;
   dmxcm_pkg::result_type              result;

   // credit-based input flow control: front stages plus queue never exceed depth
   assign occupancy = 5'(q_count) + 5'(front_status.inflight);
   assign req_stall = reset || (occupancy >= 5'(dmxcm_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   dmxcm_front #(
      .NUM_UNIVERSES  (NUM_UNIVERSES),
      .UNIVERSE_SLOTS (UNIVERSE_SLOTS),
      .OUT_BYTES      (OUT_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .in_valid    (accept),
      .in_action   (req_action),
      .in_universe (req_universe),
      .in_seq      (req_sequence_req),
      .in_plen     (req_packet_length),
      .in_bidx     (req_byte_index),
      .in_data     (req_data_byte),
      .out_valid   (front_valid),
      .out_item    (front_item),
      .status      (front_status)
   );

   dmxcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_item  (front_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .count      (q_count)
   );

   dmxcm_back #(
      .NUM_UNIVERSES (NUM_UNIVERSES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_result (result)
   );

   // result fields
   assign rsp_write_enable     = result.we;
   assign rsp_write_address    = result.addr;
   assign rsp_write_data       = result.wdata;
   assign rsp_accepted         = result.acc;
   assign rsp_sequence_error   = result.serr;
   assign rsp_restart_blank    = result.blank;
   assign rsp_universe_packets = result.upk;
   assign rsp_universe_errors  = result.uerr;
   assign rsp_total_packets    = result.tpk;
   assign rsp_total_errors     = result.terr;
   assign rsp_poll_count       = result.polls;
   assign rsp_last_first_byte  = result.lfb;

   // checks
   `DMXCM_ASSERT_IMPLIES(a_credit_bound, clock, reset, 1'b1, occupancy <= 5'(dmxcm_pkg::QUEUE_DEPTH), "queue credit overrun")
   `DMXCM_ASSERT_NEXT(a_accept_enters_front, clock, reset, accept, front_status.busy && (front_status.inflight != 3'd0), "accepted item not in front")
   `DMXCM_ASSERT_IMPLIES(a_write_needs_accept, clock, reset, rsp_valid && rsp_write_enable, rsp_accepted, "buffer write on rejected item")
   `DMXCM_ASSERT_IMPLIES(a_error_on_start, clock, reset, rsp_valid && rsp_sequence_error, rsp_restart_blank && rsp_accepted, "sequence error off packet start")

endmodule

`default_nettype wire

// ===== sv/dmxcm_front.sv =====
// Front of the mapper: configuration registers and a five-stage classifier
// that resolves universe acceptance and the buffer address. Uses dmxcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmxcm_front #(
   parameter int NUM_UNIVERSES  = 16,
   parameter int UNIVERSE_SLOTS = 512,
   parameter int OUT_BYTES      = 8192
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [2:0]                  csr_index,
   input  logic [15:0]                 csr_wdata,
   input  logic                        in_valid,
   input  logic                        in_action,
   input  logic [14:0]                 in_universe,
   input  logic [7:0]                  in_seq,
   input  logic [9:0]                  in_plen,
   input  logic [8:0]                  in_bidx,
   input  logic [7:0]                  in_data,
   output logic                        out_valid,
   output dmxcm_pkg::queue_item_type   out_item,
   output dmxcm_pkg::front_status_type status
);

   // configuration registers
   logic        enabled_ff;
   logic [14:0] start_ff;
   logic [9:0]  chans_ff;
   logic [9:0]  offset_ff;
   logic [13:0] bufb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         start_ff   <= 15'd1;
         chans_ff   <= 10'd512;
         offset_ff  <= 10'd1;
         bufb_ff    <= 14'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            dmxcm_pkg::CSR_ENABLED:        enabled_ff <= csr_wdata[0];
            dmxcm_pkg::CSR_START_UNIVERSE: start_ff   <= csr_wdata[14:0];
            dmxcm_pkg::CSR_CHANNELS:       chans_ff   <= csr_wdata[9:0];
            dmxcm_pkg::CSR_FIRST_OFFSET:   offset_ff  <= csr_wdata[9:0];
            dmxcm_pkg::CSR_BUFFER_BYTES:   bufb_ff    <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   // effective slots, offset and buffer size (first derived stage)
   logic [9:0]  slots_ff, slots_in;
   logic [9:0]  offs_ff, offs_in;
   logic [13:0] bufe_ff, bufe_in;

   always_comb begin
      if (chans_ff == 10'd0 || chans_ff > 10'(UNIVERSE_SLOTS)) begin
         slots_in = 10'(UNIVERSE_SLOTS);
      end else begin
         slots_in = chans_ff;
      end
      if (offset_ff == 10'd0) begin
         offs_in = 10'd1;
      end else if (offset_ff > slots_in) begin
         offs_in = (slots_in > 10'd1) ? slots_in - 10'd1 : 10'd1;
      end else begin
         offs_in = offset_ff;
      end
      if ({3'b000, bufb_ff} > 17'(OUT_BYTES)) begin
         bufe_in = 14'(OUT_BYTES);
      end else begin
         bufe_in = bufb_ff;
      end
   end

   // lead-in, first universe length, remainder and span (second stage)
   logic [9:0]  lead_ff, lead_in;
   logic [9:0]  first_ff, first_in;
   logic [9:0]  first_raw;
   logic [13:0] left_ff, left_in;
   logic [14:0] span_ff, span_in;

   always_comb begin
      lead_in   = offs_ff - 10'd1;
      first_raw = slots_ff - lead_in;
      first_in  = ({4'b0000, first_raw} > bufe_ff) ? bufe_ff[9:0] : first_raw;
      left_in   = bufe_ff - {4'b0000, first_in};
      span_in   = {5'b00000, offs_ff} + {1'b0, bufe_ff} - 15'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= 10'(UNIVERSE_SLOTS);
         offs_ff  <= 10'd1;
         bufe_ff  <= 14'd0;
         lead_ff  <= 10'd0;
         first_ff <= 10'd0;
         left_ff  <= 14'd0;
         span_ff  <= 15'd0;
      end else begin
         slots_ff <= slots_in;
         offs_ff  <= offs_in;
         bufe_ff  <= bufe_in;
         lead_ff  <= lead_in;
         first_ff <= first_in;
         left_ff  <= left_in;
         span_ff  <= span_in;
      end
   end

   // stage valids
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // stage 1: captured input; universe range and table index
   dmxcm_pkg::front_item_type s1_item_ff, s1_item_in;
   logic [14:0]               s1_uni_ff;
   dmxcm_pkg::front_item_type s2_item_ff, s2_item_in;
   logic [14:0]               s1_diff;

   always_comb begin
      s1_item_in.poll = in_action;
      s1_item_in.hit  = 1'b0;
      s1_item_in.idx  = '0;
      s1_item_in.seq  = in_seq;
      s1_item_in.plen = in_plen;
      s1_item_in.bidx = in_bidx;
      s1_item_in.data = in_data;
   end

   always_comb begin
      s1_diff        = s1_uni_ff - start_ff;
      s2_item_in     = s1_item_ff;
      s2_item_in.hit = enabled_ff && !s1_item_ff.poll && (s1_uni_ff >= start_ff) &&
                       (s1_diff < 15'(NUM_UNIVERSES));
      s2_item_in.idx = s1_diff[dmxcm_pkg::IDX_W-1:0];
   end

   // stage 2: universe start positions in slot units
   logic [7:0]                s2_idx_m1;
   logic [17:0]               s3_prod_ff, s3_prod_in;
   logic [17:0]               s3_prodm1_ff, s3_prodm1_in;
   dmxcm_pkg::front_item_type s3_item_ff;

   always_comb begin
      s2_idx_m1    = s2_item_ff.idx - 8'd1;
      s3_prod_in   = 18'(s2_item_ff.idx) * 18'(slots_ff);
      s3_prodm1_in = 18'(s2_idx_m1) * 18'(slots_ff);
   end

   // stage 3: mapped-universe check and clipped destination step
   dmxcm_pkg::front_item_type s4_item_ff, s4_item_in;
   logic [13:0]               s4_used_ff, s4_used_in;

   always_comb begin
      s4_item_in     = s3_item_ff;
      s4_item_in.hit = s3_item_ff.hit && (s3_prod_ff < 18'(span_ff));
      s4_used_in     = (s3_prodm1_ff > 18'(left_ff)) ? left_ff : s3_prodm1_ff[13:0];
   end

   // stage 4: destination, byte count and source offset of the universe
   dmxcm_pkg::front_item_type s5_item_ff;
   logic [13:0]               s5_dest_ff, s5_dest_in;
   logic [13:0]               s5_bytes_ff, s5_bytes_in;
   logic [8:0]                s5_src_ff, s5_src_in;
   logic [13:0]               s4_rem;

   always_comb begin
      s4_rem = left_ff - s4_used_ff;
      if (s4_item_ff.idx == '0) begin
         s5_dest_in  = 14'd0;
         s5_bytes_in = {4'b0000, first_ff};
         s5_src_in   = lead_ff[8:0];
      end else begin
         s5_dest_in  = {4'b0000, first_ff} + s4_used_ff;
         s5_bytes_in = (s4_rem > {4'b0000, slots_ff}) ? {4'b0000, slots_ff} : s4_rem;
         s5_src_in   = 9'd0;
      end
   end

   // stage 5: window check and final buffer address
   logic [8:0]  s5_off;
   logic [13:0] s5_sum;
   logic        s5_we;

   always_comb begin
      s5_off = s5_item_ff.bidx - s5_src_ff;
      s5_sum = s5_dest_ff + {5'b00000, s5_off};
      s5_we  = s5_item_ff.hit && ({1'b0, s5_item_ff.bidx} < s5_item_ff.plen) &&
               (s5_item_ff.bidx >= s5_src_ff) && ({5'b00000, s5_off} < s5_bytes_ff);

      out_item.poll  = s5_item_ff.poll;
      out_item.acc   = s5_item_ff.hit;
      out_item.first = (s5_item_ff.bidx == 9'd0);
      out_item.we    = s5_we;
      out_item.addr  = s5_we ? s5_sum[12:0] : 13'd0;
      out_item.data  = s5_item_ff.data;
      out_item.seq   = s5_item_ff.seq;
      out_item.idx   = s5_item_ff.idx;
   end

   // pipeline payload, follows the valids
   always_ff @(posedge clock) begin
      s1_item_ff   <= s1_item_in;
      s1_uni_ff    <= in_universe;
      s2_item_ff   <= s2_item_in;
      s3_item_ff   <= s2_item_ff;
      s3_prod_ff   <= s3_prod_in;
      s3_prodm1_ff <= s3_prodm1_in;
      s4_item_ff   <= s4_item_in;
      s4_used_ff   <= s4_used_in;
      s5_item_ff   <= s4_item_ff;
      s5_dest_ff   <= s5_dest_in;
      s5_bytes_ff  <= s5_bytes_in;
      s5_src_ff    <= s5_src_in;
   end

   assign out_valid       = s5_valid_ff;
   assign status.inflight = 3'($countones({s1_valid_ff, s2_valid_ff, s3_valid_ff,
                                           s4_valid_ff, s5_valid_ff}));
   assign status.busy     = s1_valid_ff | s2_valid_ff | s3_valid_ff | s4_valid_ff |
                            s5_valid_ff;

endmodule

`default_nettype wire

// ===== sv/dmxcm_queue.sv =====
// Short item queue between the classifier front and the state-update back.
// Uses dmxcm_pkg for depth and item type.
`timescale 1ns / 1ps
`default_nettype none

module dmxcm_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  dmxcm_pkg::queue_item_type       push_item,
   input  logic                            pop,
   output logic                            head_valid,
   output dmxcm_pkg::queue_item_type       head_item,
   output logic [dmxcm_pkg::QCNT_W-1:0]    count
);

   dmxcm_pkg::queue_item_type          slot_ff [dmxcm_pkg::QUEUE_DEPTH];
   logic [dmxcm_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [dmxcm_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [dmxcm_pkg::QCNT_W-1:0]       count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

`default_nettype wire

// ===== sv/dmxcm_back.sv =====
// Back of the mapper: per-universe sequence and counter memory, totals and
// the result register. Uses dmxcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmxcm_back #(
   parameter int NUM_UNIVERSES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  dmxcm_pkg::queue_item_type head_item,
   output logic                      pop,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output dmxcm_pkg::result_type     rsp_result
);

   localparam int IdxW = (NUM_UNIVERSES > 1) ? $clog2(NUM_UNIVERSES) : 1;

   // state memory with per-entry live bits (unwritten entries read as zero)
   dmxcm_pkg::uni_state_type  state_mem [NUM_UNIVERSES];
   logic [NUM_UNIVERSES-1:0]  live_ff;

   // read stage: item plus registered memory data and forwarded value
   logic                      r_valid_ff, r_valid_in;
   dmxcm_pkg::queue_item_type r_item_ff;
   dmxcm_pkg::uni_state_type  rd_state_ff;
   logic                      rd_live_ff;
   logic                      fwd_ff, fwd_in;
   dmxcm_pkg::uni_state_type  fwd_state_ff;

   // result register and totals
   logic                      rsp_valid_ff, rsp_valid_in;
   dmxcm_pkg::result_type     rsp_ff, result_in;
   logic [31:0]               tpk_ff, tpk_in;
   logic [31:0]               terr_ff, terr_in;
   logic [31:0]               polls_ff, polls_in;
   logic [7:0]                lfb_ff, lfb_in;

   logic                      rsp_load, r_fire, wr, start;
   logic [IdxW-1:0]           rd_idx, wr_idx;
   dmxcm_pkg::uni_state_type  cur_state, nxt_state;
   logic                      serr;

   // handshake between queue, read stage and result register
   always_comb begin
      rsp_load     = !rsp_valid_ff || !rsp_stall;
      r_fire       = r_valid_ff && rsp_load;
      pop          = head_valid && (!r_valid_ff || r_fire);
      r_valid_in   = pop ? 1'b1 : (r_fire ? 1'b0 : r_valid_ff);
      rsp_valid_in = r_fire ? 1'b1 : (rsp_load ? 1'b0 : rsp_valid_ff);
      rd_idx       = head_item.idx[IdxW-1:0];
      wr_idx       = r_item_ff.idx[IdxW-1:0];
      start        = r_item_ff.acc && r_item_ff.first;
      wr           = r_fire && start;
      fwd_in       = wr && (wr_idx == rd_idx);
   end

   // sequence tracking and counter update on packet start
   always_comb begin
      if (fwd_ff) begin
         cur_state = fwd_state_ff;
      end else if (rd_live_ff) begin
         cur_state = rd_state_ff;
      end else begin
         cur_state = '0;
      end
      nxt_state = cur_state;
      serr      = 1'b0;
      if (start) begin
         if (r_item_ff.seq != cur_state.seq && r_item_ff.seq != 8'd0) begin
            nxt_state.errs = cur_state.errs + 32'd1;
            serr           = 1'b1;
         end
         nxt_state.seq  = r_item_ff.seq + 8'd1;
         nxt_state.pkts = cur_state.pkts + 32'd1;
      end
   end

   // totals and result
   always_comb begin
      tpk_in   = tpk_ff;
      terr_in  = terr_ff;
      polls_in = polls_ff;
      lfb_in   = lfb_ff;
      if (r_fire) begin
         if (start) begin
            tpk_in = tpk_ff + 32'd1;
            lfb_in = r_item_ff.data;
         end
         if (serr) begin
            terr_in = terr_ff + 32'd1;
         end
         if (r_item_ff.poll) begin
            polls_in = polls_ff + 32'd1;
         end
      end
      result_in.we    = r_item_ff.we;
      result_in.addr  = r_item_ff.addr;
      result_in.wdata = r_item_ff.we ? r_item_ff.data : 8'd0;
      result_in.acc   = r_item_ff.acc;
      result_in.serr  = serr;
      result_in.blank = start;
      result_in.upk   = r_item_ff.acc ? nxt_state.pkts : 32'd0;
      result_in.uerr  = r_item_ff.acc ? nxt_state.errs : 32'd0;
      result_in.tpk   = tpk_in;
      result_in.terr  = terr_in;
      result_in.polls = polls_in;
      result_in.lfb   = lfb_in;
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr) begin
         state_mem[wr_idx] <= nxt_state;
      end
      if (pop) begin
         rd_state_ff  <= state_mem[rd_idx];
         fwd_state_ff <= nxt_state;
         r_item_ff    <= head_item;
      end
      if (r_fire) begin
         rsp_ff <= result_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         rd_live_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         r_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tpk_ff       <= 32'd0;
         terr_ff      <= 32'd0;
         polls_ff     <= 32'd0;
         lfb_ff       <= 8'd0;
      end else begin
         if (wr) begin
            live_ff[wr_idx] <= 1'b1;
         end
         if (pop) begin
            rd_live_ff <= live_ff[rd_idx];
            fwd_ff     <= fwd_in;
         end
         r_valid_ff   <= r_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         tpk_ff       <= tpk_in;
         terr_ff      <= terr_in;
         polls_ff     <= polls_in;
         lfb_ff       <= lfb_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

`default_nettype wire
